### hdl/infix_to_postfix_converter_assert.svh
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_assert.svh
// assertion macros used by the converter datapath
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// same-cycle implication
`define ITP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// types, character codes and operator tables of the infix to postfix converter
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int CHAR_W = 8;
  localparam int OPC_W  = 3;
  localparam int STS_W  = 2;
  localparam int PRIO_W = 3;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [OPC_W-1:0]  opcode_t;
  typedef logic [STS_W-1:0]  status_t;
  typedef logic [PRIO_W-1:0] prio_t;

  // stacked operator codes
  localparam opcode_t OPC_OPEN   = 3'd0;
  localparam opcode_t OPC_ASSIGN = 3'd1;
  localparam opcode_t OPC_ADD    = 3'd2;
  localparam opcode_t OPC_SUB    = 3'd3;
  localparam opcode_t OPC_MUL    = 3'd4;
  localparam opcode_t OPC_DIV    = 3'd5;

  localparam char_t CH_OPEN    = 8'h28;
  localparam char_t CH_CLOSE   = 8'h29;
  localparam char_t CH_ASSIGN  = 8'h3d;
  localparam char_t CH_ADD     = 8'h2b;
  localparam char_t CH_SUB     = 8'h2d;
  localparam char_t CH_MUL     = 8'h2a;
  localparam char_t CH_DIV     = 8'h2f;
  localparam char_t CH_SPACE   = 8'h20;
  localparam char_t CH_NEWLINE = 8'h0a;
  localparam char_t CH_NUL     = 8'h00;

  localparam status_t STS_OK        = 2'd0;
  localparam status_t STS_OVERFLOW  = 2'd1;
  localparam status_t STS_UNMATCHED = 2'd2;

  typedef enum logic [2:0] {
    KIND_OPERAND,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_OPER,
    KIND_END
  } kind_e;

  typedef enum logic [2:0] {
    SEL_CHAR,
    SEL_SPACE,
    SEL_NEWLINE,
    SEL_TOP,
    SEL_OVERFLOW,
    SEL_UNMATCHED
  } emit_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_POP,
    S_CLOSE,
    S_OPER
  } state_e;

  typedef struct packed {
    logic      accept;
    logic      rd_top;
    logic      rd_below;
    logic      push;
    logic      pop;
    logic      emit;
    emit_sel_e emit_sel;
    logic      flush;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  empty;
    logic  full;
    logic  top_open;
    logic  top_ge;
    logic  pend_valid;
    logic  out_free;
  } dp_status_t;

  function automatic char_t opcode_char(opcode_t code);
    char_t ch;
    case (code)
      OPC_OPEN:   ch = CH_OPEN;
      OPC_ASSIGN: ch = CH_ASSIGN;
      OPC_ADD:    ch = CH_ADD;
      OPC_SUB:    ch = CH_SUB;
      OPC_MUL:    ch = CH_MUL;
      OPC_DIV:    ch = CH_DIV;
      default:    ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic prio_t opcode_prio(opcode_t code);
    prio_t pr;
    case (code) inside
      OPC_OPEN:         pr = 3'd1;
      OPC_ASSIGN:       pr = 3'd3;
      OPC_ADD, OPC_SUB: pr = 3'd4;
      OPC_MUL, OPC_DIV: pr = 3'd5;
      default:          pr = 3'd0;
    endcase
    return pr;
  endfunction

endpackage

### hdl/itp_in_if.sv
// ----------------------------------------------------------------------------
// itp_in_if
// input channel: one infix character or end mark per beat
// ----------------------------------------------------------------------------
interface itp_in_if;

  logic                valid;
  logic                ready;
  logic                func;
  itp_pkg::char_t      in_char;

  modport source (output valid, output func, output in_char, input ready);
  modport sink   (input valid, input func, input in_char, output ready);

endinterface

### hdl/itp_out_if.sv
// ----------------------------------------------------------------------------
// itp_out_if
// output channel: one postfix character with last and status per beat
// ----------------------------------------------------------------------------
interface itp_out_if;

  logic                valid;
  logic                ready;
  itp_pkg::char_t      out_char;
  logic                last;
  itp_pkg::status_t    status;

  modport source (output valid, output out_char, output last, output status, input ready);
  modport sink   (input valid, input out_char, input last, input status, output ready);

endinterface

### hdl/itp_ram.sv
// ----------------------------------------------------------------------------
// itp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module itp_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/itp_ctrl.sv
// ----------------------------------------------------------------------------
// itp_ctrl
// sequencer of the converter: decides pushes, pops and emitted beats
// ----------------------------------------------------------------------------
module itp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  itp_pkg::dp_status_t status_i,
  output itp_pkg::ctrl_cmd_t  cmd_o
);

  import itp_pkg::*;

  state_e state_q, state_d;
  logic   can_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    can_emit   = !status_i.pend_valid || status_i.out_free;

    case (state_q)
      S_IDLE: begin
        // last beat of the previous item leaves the holding register
        cmd_o.flush = status_i.pend_valid && status_i.out_free;
        in_ready_o  = can_emit;
        if (in_valid_i && can_emit) begin
          cmd_o.accept = 1'b1;
          cmd_o.rd_top = 1'b1;
          state_d      = S_EVAL;
        end
      end

      S_EVAL: begin
        if (can_emit) begin
          case (status_i.kind)
            KIND_OPERAND: begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_sel = SEL_CHAR;
              state_d        = S_IDLE;
            end
            KIND_OPEN: begin
              if (status_i.full) begin
                cmd_o.emit     = 1'b1;
                cmd_o.emit_sel = SEL_OVERFLOW;
              end else begin
                cmd_o.push = 1'b1;
              end
              state_d = S_IDLE;
            end
            KIND_CLOSE: begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_sel = SEL_SPACE;
              state_d        = S_CLOSE;
            end
            KIND_OPER: begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_sel = SEL_SPACE;
              state_d        = S_OPER;
            end
            KIND_END: begin
              cmd_o.emit = 1'b1;
              if (status_i.empty) begin
                cmd_o.emit_sel = SEL_NEWLINE;
                state_d        = S_IDLE;
              end else begin
                cmd_o.emit_sel = SEL_SPACE;
                state_d        = S_POP;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_POP: begin
        if (can_emit) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = SEL_TOP;
          cmd_o.pop      = 1'b1;
          cmd_o.rd_below = 1'b1;
          state_d        = S_EVAL;
        end
      end

      S_CLOSE: begin
        if (status_i.empty) begin
          if (can_emit) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = SEL_UNMATCHED;
            state_d        = S_IDLE;
          end
        end else if (status_i.top_open) begin
          cmd_o.pop = 1'b1;
          state_d   = S_IDLE;
        end else if (can_emit) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = SEL_TOP;
          cmd_o.pop      = 1'b1;
          cmd_o.rd_below = 1'b1;
        end
      end

      S_OPER: begin
        if (!status_i.empty && status_i.top_ge) begin
          if (can_emit) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = SEL_TOP;
            cmd_o.pop      = 1'b1;
            cmd_o.rd_below = 1'b1;
          end
        end else if (status_i.full) begin
          if (can_emit) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = SEL_OVERFLOW;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule

### hdl/itp_dp.sv
// ----------------------------------------------------------------------------
// itp_dp
// datapath: item register, operator stack, holding register, output register
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_assert.svh"

module itp_dp #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itp_pkg::ctrl_cmd_t  cmd_i,
  output itp_pkg::dp_status_t status_o,
  input  logic                in_func_i,
  input  itp_pkg::char_t      in_char_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output itp_pkg::char_t      out_char_o,
  output logic                out_last_o,
  output itp_pkg::status_t    out_status_o
);

  import itp_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  logic            func_q;
  char_t           char_q;
  kind_e           kind;
  opcode_t         item_code;

  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   rd_count;
  opcode_t         top_code;

  logic            pend_valid_q;
  char_t           pend_char_q;
  status_t         pend_status_q;
  char_t           emit_char;
  status_t         emit_status;

  logic            out_valid_q;
  char_t           out_char_q;
  logic            out_last_q;
  status_t         out_status_q;
  logic            out_free;
  logic            out_load;

  // item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= in_func_i;
      char_q <= in_char_i;
    end
  end

  always_comb begin
    kind      = KIND_OPERAND;
    item_code = OPC_OPEN;
    if (func_q) begin
      kind = KIND_END;
    end else begin
      case (char_q)
        CH_OPEN:   kind = KIND_OPEN;
        CH_CLOSE:  kind = KIND_CLOSE;
        CH_ASSIGN: begin
          kind      = KIND_OPER;
          item_code = OPC_ASSIGN;
        end
        CH_ADD: begin
          kind      = KIND_OPER;
          item_code = OPC_ADD;
        end
        CH_SUB: begin
          kind      = KIND_OPER;
          item_code = OPC_SUB;
        end
        CH_MUL: begin
          kind      = KIND_OPER;
          item_code = OPC_MUL;
        end
        CH_DIV: begin
          kind      = KIND_OPER;
          item_code = OPC_DIV;
        end
        default: kind = KIND_OPERAND;
      endcase
    end
  end

  // operator stack
  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // top lives at count-1, the one below at count-2
  assign rd_count = cmd_i.rd_below ? (count_q - CW'(2)) : (count_q - CW'(1));

  itp_ram #(
    .WIDTH (OPC_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (item_code),
    .re_i    (cmd_i.rd_top || cmd_i.rd_below),
    .raddr_i (rd_count[AW-1:0]),
    .rdata_o (top_code)
  );

  // beat selection
  always_comb begin
    case (cmd_i.emit_sel)
      SEL_CHAR: begin
        emit_char   = char_q;
        emit_status = STS_OK;
      end
      SEL_SPACE: begin
        emit_char   = CH_SPACE;
        emit_status = STS_OK;
      end
      SEL_NEWLINE: begin
        emit_char   = CH_NEWLINE;
        emit_status = STS_OK;
      end
      SEL_TOP: begin
        emit_char   = opcode_char(top_code);
        emit_status = STS_OK;
      end
      SEL_OVERFLOW: begin
        emit_char   = CH_NUL;
        emit_status = STS_OVERFLOW;
      end
      SEL_UNMATCHED: begin
        emit_char   = CH_NUL;
        emit_status = STS_UNMATCHED;
      end
      default: begin
        emit_char   = CH_NUL;
        emit_status = STS_OK;
      end
    endcase
  end

  // holding register: a beat waits here until it is known whether it is last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.flush) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pend_char_q   <= emit_char;
      pend_status_q <= emit_status;
    end
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (cmd_i.emit && pend_valid_q) || cmd_i.flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q   <= pend_char_q;
      out_status_q <= pend_status_q;
      out_last_q   <= cmd_i.flush;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

  assign status_o.kind       = kind;
  assign status_o.empty      = (count_q == '0);
  assign status_o.full       = (count_q == FULL_COUNT);
  assign status_o.top_open   = (top_code == OPC_OPEN);
  assign status_o.top_ge     = (opcode_prio(top_code) >= opcode_prio(item_code));
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  `ITP_ASSERT_IMPLIES(a_pop_nonempty, clk_i, rst_ni, cmd_i.pop, count_q != '0, "pop on empty stack")
  `ITP_ASSERT_IMPLIES(a_push_not_full, clk_i, rst_ni, cmd_i.push, count_q != FULL_COUNT, "push on full stack")
  `ITP_ASSERT_IMPLIES(a_no_beat_overwrite, clk_i, rst_ni, out_load, out_free, "output beat overwritten")
  `ITP_ASSERT_NEXT(a_pop_count, clk_i, rst_ni, cmd_i.pop, count_q == $past(count_q) - 1'b1, "pop count slip")

endmodule

### hdl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// shunting-yard conversion of an infix character stream into postfix beats
// ----------------------------------------------------------------------------
// item_i carries one infix character per beat (func 0) or an end mark (func 1).
// result_o carries postfix characters; last marks the final beat of an item,
// status flags a dropped push on a full stack or an unmatched ')'.
// an operand's beat enters the holding register when the item is evaluated;
// each stack pop, and the push or dropped push that ends an operator, is a
// step of its own, and an end mark takes an evaluation and a pop per entry.
// the top entry comes from the registered read of the stack ram: it is
// fetched in the accept cycle and evaluated in the next.
// a beat is held back one step until the next beat or the item's end is known,
// so last is exact; it moves to the output register in the next idle cycle,
// which also accepts the next item.
// reset empties the stack and drops any beat in flight; stack contents need
// no clearing. when result_o stalls, the sequencer holds any step that emits a beat and item_i
// stays not ready until the held beat can move on.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  itp_in_if.sink    item_i,
  itp_out_if.source result_o
);

  import itp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  itp_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_func_i    (item_i.func),
    .in_char_i    (item_i.in_char),
    .out_ready_i  (result_o.ready),
    .out_valid_o  (result_o.valid),
    .out_char_o   (result_o.out_char),
    .out_last_o   (result_o.last),
    .out_status_o (result_o.status)
  );

endmodule
